/* rtl/bale_pkg.sv */
`timescale 1ns / 1ps
package bale_pkg;
    localparam int Depth = 16;
    localparam int IdxW = 4;
    localparam int CntW = 5;

    typedef enum logic [2:0] {
        K_APPEND = 3'd0,
        K_INSERT = 3'd1,
        K_DELETE = 3'd2,
        K_LSEARCH = 3'd3,
        K_BSEARCH = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_FULL = 2'd1,
        ST_RANGE = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    localparam logic [0:0] ADDR_CAPACITY = 1'b0;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] position;
        logic signed [31:0] operand;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] found_at;
        logic signed [31:0] removed_value;
        logic [4:0] count_now;
    } t_rsp;

    // per-cycle command from the sequencer to every cell
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic load;
        logic swap;
        logic [IdxW-1:0] lo;
        logic [IdxW-1:0] hi;
        logic [IdxW-1:0] sel;
        logic [31:0] data;
    } t_cell_cmd;
endpackage

/* rtl/bounded_array_list_engine_core.sv */
`timescale 1ns / 1ps
// Linear search compares one cell per cycle and binary search narrows the
// range around its midpoint; append, insert and delete act in their first step.
// One item at a time: a new item is accepted only back in S_IDLE, after
// S_DONE has given the result of the last one.
// Result strobe o_done lasts one cycle; the receiver cannot stall.
// Reset (synchronous, active low) clears count to 0 and capacity to 16.
module bounded_array_list_engine_core
    import bale_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_rsp        o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [CntW-1:0] r_cap;
    t_cell_cmd cmd;
    logic [Depth-1:0][31:0] vals;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CntW'(16);
        end else if (psel && penable && pwrite && paddr[2] == ADDR_CAPACITY) begin
            r_cap <= pwdata[CntW-1:0];
        end
    end
    assign prdata = (paddr[2] == ADDR_CAPACITY) ? {27'd0, r_cap} : 32'd0;

    bale_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_req(i_req),
        .i_cap(r_cap), .i_vals(vals), .o_cmd(cmd), .o_busy(busy),
        .o_done(o_done), .o_rsp(o_rsp)
    );

    for (genvar g = 0; g < Depth; g++) begin : g_cell
        bale_cell u_cell (
            .i_clk(i_clk), .i_index(IdxW'(g)), .i_cmd(cmd),
            .i_below(vals[(g + Depth - 1) % Depth]),
            .i_above(vals[(g + 1) % Depth]),
            .i_head(vals[0]),
            .o_value(vals[g])
        );
    end

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("done without busy");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_rsp.count_now <= CntW'(Depth)) else $error("count overflow");
    a_start_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept lost");
endmodule

/* rtl/bale_cell.sv */
`timescale 1ns / 1ps
module bale_cell
    import bale_pkg::*;
(
    input  logic             i_clk,
    input  logic [IdxW-1:0]  i_index,
    input  t_cell_cmd        i_cmd,
    input  logic [31:0]      i_below,
    input  logic [31:0]      i_above,
    input  logic [31:0]      i_head,
    output logic [31:0]      o_value
);
    logic [31:0] r_value;
    logic        in_rng;

    assign in_rng = (i_index >= i_cmd.lo) && (i_index <= i_cmd.hi);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_index == i_cmd.sel) begin
            r_value <= i_cmd.data;
        end else if (i_cmd.shift_up && in_rng) begin
            r_value <= i_below;
        end else if (i_cmd.shift_down && in_rng) begin
            r_value <= i_above;
        end else if (i_cmd.swap && i_index == i_cmd.sel) begin
            r_value <= i_head;
        end else if (i_cmd.swap && i_index == '0) begin
            r_value <= i_cmd.data;
        end
    end

    assign o_value = r_value;
endmodule

/* rtl/bale_seq.sv */
`timescale 1ns / 1ps
module bale_seq
    import bale_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_req              i_req,
    input  logic [CntW-1:0]   i_cap,
    input  logic [Depth-1:0][31:0] i_vals,
    output t_cell_cmd         o_cmd,
    output logic              o_busy,
    output logic              o_done,
    output t_rsp              o_rsp
);
    t_state r_state, n_state;
    t_req r_req;
    logic [CntW-1:0] r_count, n_count;
    logic [CntW-1:0] r_i;
    logic [CntW-1:0] r_lo, r_hi;
    t_rsp r_rsp, n_rsp;
    logic [CntW-1:0] n_i, n_lo, n_hi;
    logic step_end;
    logic [CntW-1:0] cap_eff;
    logic [CntW:0] mid_sum;
    logic [CntW-1:0] mid;
    logic [31:0] mid_val, i_val;

    assign cap_eff = (i_cap > CntW'(Depth)) ? CntW'(Depth) : i_cap;
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid = mid_sum[CntW:1];
    assign mid_val = i_vals[mid[IdxW-1:0]];
    assign i_val = i_vals[r_i[IdxW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_req <= i_req;
        end
        r_i <= n_i;
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_rsp <= n_rsp;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_WALK;
            S_WALK: if (step_end) n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.data = r_req.operand;
        n_count = r_count;
        n_i = r_i;
        n_lo = r_lo;
        n_hi = r_hi;
        n_rsp = r_rsp;
        step_end = 1'b1;
        case (r_state)
            S_IDLE: begin
                n_i = '0;
                n_lo = '0;
                n_hi = r_count - 1'b1;
                n_rsp = '0;
            end
            S_WALK: begin
                n_rsp.count_now = r_count;
                case (t_kind'(r_req.kind))
                    K_APPEND: begin
                        if (r_count >= cap_eff) begin
                            n_rsp.status = ST_FULL;
                        end else begin
                            o_cmd.load = 1'b1;
                            o_cmd.sel = r_count[IdxW-1:0];
                            n_count = r_count + 1'b1;
                            n_rsp.count_now = n_count;
                        end
                    end
                    K_INSERT: begin
                        if (r_req.position > r_count) begin
                            n_rsp.status = ST_RANGE;
                        end else if (r_count >= cap_eff) begin
                            n_rsp.status = ST_FULL;
                        end else begin
                            // cells above the slot shift up; the slot itself loads
                            o_cmd.shift_up = 1'b1;
                            o_cmd.lo = r_req.position[IdxW-1:0];
                            o_cmd.hi = r_count[IdxW-1:0];
                            o_cmd.load = 1'b1;
                            o_cmd.sel = r_req.position[IdxW-1:0];
                            n_count = r_count + 1'b1;
                            n_rsp.count_now = n_count;
                        end
                    end
                    K_DELETE: begin
                        if (r_req.position >= r_count) begin
                            n_rsp.status = ST_RANGE;
                        end else begin
                            n_rsp.removed_value = i_vals[r_req.position[IdxW-1:0]];
                            o_cmd.shift_down = 1'b1;
                            o_cmd.lo = r_req.position[IdxW-1:0];
                            o_cmd.hi = IdxW'(r_count - 2'd2);
                            if (r_count < 2) o_cmd.shift_down = 1'b0;
                            if (r_req.position + 1'b1 >= r_count) o_cmd.shift_down = 1'b0;
                            n_count = r_count - 1'b1;
                            n_rsp.count_now = n_count;
                        end
                    end
                    K_LSEARCH: begin
                        // walk one entry per cycle
                        if (r_i >= r_count) begin
                            n_rsp.status = ST_MISS;
                        end else if (i_val == r_req.operand) begin
                            o_cmd.swap = 1'b1;
                            o_cmd.sel = r_i[IdxW-1:0];
                            o_cmd.data = i_val;
                            n_rsp.status = ST_OK;
                        end else begin
                            n_i = r_i + 1'b1;
                            step_end = 1'b0;
                        end
                    end
                    K_BSEARCH: begin
                        if (r_count == '0 || r_lo > r_hi || r_hi[CntW-1]) begin
                            n_rsp.status = ST_MISS;
                        end else if (mid_val == r_req.operand) begin
                            n_rsp.found_at = mid[IdxW-1:0];
                        end else begin
                            step_end = 1'b0;
                            if ($signed(r_req.operand) < $signed(mid_val)) begin
                                if (mid == '0) begin
                                    n_rsp.status = ST_MISS;
                                    step_end = 1'b1;
                                end
                                n_hi = mid - 1'b1;
                            end else begin
                                n_lo = mid + 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_rsp = r_rsp;
endmodule
